// ===== sv/sstf_disk_scheduler_assert.svh =====
// assertion macros for the sstf disk scheduler
`ifndef SSTF_DISK_SCHEDULER_ASSERT_SVH
`define SSTF_DISK_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SSTF_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sstf check failed");

// next-cycle implication, disabled in reset
`define SSTF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sstf check failed");

`endif

// ===== sv/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// shared constants and word types of the sstf disk scheduler
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int CYL_BITS    = 16;
    localparam int SEEK_BITS   = 22;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SEEK_BITS-1:0] SEEK_MAX = {SEEK_BITS{1'b1}};

    typedef struct packed {
        logic [CYL_BITS-1:0] cylinder;
        logic                last_request;
    } req_word_t;

    typedef struct packed {
        logic [CYL_BITS-1:0]  served_cylinder;
        logic [CYL_BITS-1:0]  step_distance;
        logic [SEEK_BITS-1:0] total_seek;
        logic                 final_service;
        logic                 overflow;
    } rsp_word_t;

    typedef struct packed {
        logic shift;
        logic flush;
    } cell_ctrl_t;

    typedef struct packed {
        logic en;
        logic first;
    } trk_ctrl_t;

endpackage

// ===== sv/sstf_cell.sv =====
// ----------------------------------------------------------------------------
// sstf_cell
// one queue cell: a held cylinder and its pending bit, shifted from its neighbor
// ----------------------------------------------------------------------------
module sstf_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sstf_pkg::cell_ctrl_t         ctrl,
    input  logic                         pick_clr,
    input  logic [sstf_pkg::CYL_BITS-1:0] shift_cyl,
    input  logic                         shift_vld,
    output logic [sstf_pkg::CYL_BITS-1:0] cyl,
    output logic                         vld
);

    logic [sstf_pkg::CYL_BITS-1:0] cyl_reg;
    logic                          vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            priority if (ctrl.flush)
            begin
                vld_reg <= 1'b0;
            end
            else if (ctrl.shift)
            begin
                vld_reg <= shift_vld;
            end
            else if (pick_clr)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            cyl_reg <= shift_cyl;
        end
    end

    assign cyl = cyl_reg;
    assign vld = vld_reg;

endmodule

// ===== sv/sstf_nearest.sv =====
// ----------------------------------------------------------------------------
// sstf_nearest
// tracks the nearest pending cylinder as the ring rotates past it
// ----------------------------------------------------------------------------
module sstf_nearest (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sstf_pkg::trk_ctrl_t           ctrl,
    input  logic [sstf_pkg::CYL_BITS-1:0] head,
    input  logic [sstf_pkg::CYL_BITS-1:0] cand_cyl,
    input  logic                          cand_vld,
    input  logic [sstf_pkg::IDX_W-1:0]    cand_idx,
    output logic [sstf_pkg::CYL_BITS-1:0] best_cyl,
    output logic [sstf_pkg::CYL_BITS-1:0] best_dist,
    output logic [sstf_pkg::IDX_W-1:0]    best_idx
);

    logic                          found_reg;
    logic                          found_next;
    logic [sstf_pkg::CYL_BITS-1:0] best_cyl_reg;
    logic [sstf_pkg::CYL_BITS-1:0] best_dist_reg;
    logic [sstf_pkg::IDX_W-1:0]    best_idx_reg;
    logic [sstf_pkg::CYL_BITS-1:0] cand_dist;
    logic                          take;

    always_comb
    begin
        cand_dist = (cand_cyl >= head) ? (cand_cyl - head) : (head - cand_cyl);
        take = ctrl.en && cand_vld &&
               (ctrl.first || !found_reg || (cand_dist < best_dist_reg) ||
                ((cand_dist == best_dist_reg) && (cand_cyl < best_cyl_reg)));
        found_next = found_reg;
        if (ctrl.en)
        begin
            found_next = ctrl.first ? cand_vld : (found_reg | cand_vld);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_cyl_reg  <= cand_cyl;
            best_dist_reg <= cand_dist;
            best_idx_reg  <= cand_idx;
        end
    end

    assign best_cyl  = best_cyl_reg;
    assign best_dist = best_dist_reg;
    assign best_idx  = best_idx_reg;

endmodule

// ===== sv/sstf_disk_scheduler.sv =====
// ----------------------------------------------------------------------------
// sstf_disk_scheduler
// shortest seek time first scheduler over a ring of request cells
// ----------------------------------------------------------------------------
// in channel (in_valid/in_ready/in_data): one request word per cylinder; a word
// with last_request set closes the batch. words are taken only while the block
// is idle, one per cycle; requests beyond QUEUE_DEPTH are dropped and flagged.
// out channel (out_valid/out_ready/out_data): one word per serviced request in
// service order; the last carries final_service, all carry overflow when the
// batch dropped requests.
// each service rotates the request ring once past the nearest-cylinder tracker:
// a scan over all QUEUE_DEPTH cells, then an emit step that posts the result;
// the first result of a batch follows one full scan after the closing word.
// a stalled receiver holds the output register; the next scan still runs and
// its result waits until the register frees up.
// cfg_wr_en/cfg_wr_data write start_head, the head cylinder each batch starts
// from. reset empties the queue, clears start_head and the output register.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sstf_pkg::req_word_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sstf_pkg::rsp_word_t           out_data,
    input  logic                          cfg_wr_en,
    input  logic [sstf_pkg::CYL_BITS-1:0] cfg_wr_data
);

    `include "sstf_disk_scheduler_assert.svh"

    localparam int D = sstf_pkg::QUEUE_DEPTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    logic [sstf_pkg::IDX_W-1:0]      step_reg;
    logic [sstf_pkg::CNT_W-1:0]      count_reg;
    logic [sstf_pkg::CNT_W-1:0]      rem_reg;
    logic [sstf_pkg::CYL_BITS-1:0]   head_reg;
    logic [sstf_pkg::SEEK_BITS-1:0]  seek_reg;
    logic                            dropped_reg;
    logic [sstf_pkg::CYL_BITS-1:0]   start_head_reg;
    logic                            out_valid_reg;
    sstf_pkg::rsp_word_t             out_data_reg;

    logic                            in_fire;
    logic                            has_room;
    logic                            load_shift;
    logic                            emit_fire;
    logic                            last_emit;
    logic [sstf_pkg::CNT_W-1:0]      count_next;
    logic [sstf_pkg::SEEK_BITS:0]    seek_wide;
    logic [sstf_pkg::SEEK_BITS-1:0]  seek_next;

    sstf_pkg::cell_ctrl_t            cell_ctrl;
    sstf_pkg::trk_ctrl_t             trk_ctrl;
    logic [sstf_pkg::CYL_BITS-1:0]   cell_cyl [D];
    logic [D-1:0]                    cell_vld;
    logic [sstf_pkg::CYL_BITS-1:0]   head_cyl;
    logic                            head_vld;
    logic [sstf_pkg::CYL_BITS-1:0]   best_cyl;
    logic [sstf_pkg::CYL_BITS-1:0]   best_dist;
    logic [sstf_pkg::IDX_W-1:0]      best_idx;
    logic [sstf_pkg::IDX_W-1:0]      cand_idx;

    always_comb
    begin
        in_fire    = in_valid && (state_reg == ST_IDLE);
        has_room   = (count_reg < sstf_pkg::CNT_W'(D));
        load_shift = in_fire && has_room;
        count_next = count_reg + sstf_pkg::CNT_W'(has_room);
        emit_fire  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
        last_emit  = (rem_reg == sstf_pkg::CNT_W'(1));
        seek_wide  = {1'b0, seek_reg} + (sstf_pkg::SEEK_BITS+1)'(best_dist);
        seek_next  = seek_wide[sstf_pkg::SEEK_BITS] ? sstf_pkg::SEEK_MAX
                                                    : seek_wide[sstf_pkg::SEEK_BITS-1:0];
        cell_ctrl.shift = load_shift || (state_reg == ST_SCAN);
        cell_ctrl.flush = emit_fire && last_emit;
        trk_ctrl.en     = (state_reg == ST_SCAN);
        trk_ctrl.first  = (step_reg == '0);
        cand_idx        = sstf_pkg::IDX_W'(D - 1) - step_reg;
        head_cyl        = load_shift ? in_data.cylinder : cell_cyl[D-1];
        head_vld        = load_shift ? 1'b1 : cell_vld[D-1];
    end

    // request ring
    for (genvar i = 0; i < D; i++)
    begin : g_cell
        logic [sstf_pkg::CYL_BITS-1:0] src_cyl;
        logic                          src_vld;
        if (i == 0)
        begin : g_first
            assign src_cyl = head_cyl;
            assign src_vld = head_vld;
        end
        else
        begin : g_rest
            assign src_cyl = cell_cyl[i-1];
            assign src_vld = cell_vld[i-1];
        end

        sstf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .pick_clr  (emit_fire && (best_idx == sstf_pkg::IDX_W'(i))),
            .shift_cyl (src_cyl),
            .shift_vld (src_vld),
            .cyl       (cell_cyl[i]),
            .vld       (cell_vld[i])
        );
    end

    sstf_nearest u_nearest (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (trk_ctrl),
        .head      (head_reg),
        .cand_cyl  (cell_cyl[D-1]),
        .cand_vld  (cell_vld[D-1]),
        .cand_idx  (cand_idx),
        .best_cyl  (best_cyl),
        .best_dist (best_dist),
        .best_idx  (best_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            rem_reg        <= '0;
            head_reg       <= '0;
            seek_reg       <= '0;
            dropped_reg    <= 1'b0;
            start_head_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_head_reg <= cfg_wr_data;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        count_reg <= count_next;
                        if (!has_room)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (in_data.last_request)
                        begin
                            rem_reg   <= count_next;
                            head_reg  <= start_head_reg;
                            seek_reg  <= '0;
                            step_reg  <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    step_reg <= step_reg + sstf_pkg::IDX_W'(1);
                    if (step_reg == sstf_pkg::IDX_W'(D - 1))
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_data_reg.served_cylinder <= best_cyl;
                        out_data_reg.step_distance   <= best_dist;
                        out_data_reg.total_seek      <= seek_next;
                        out_data_reg.final_service   <= last_emit;
                        out_data_reg.overflow        <= dropped_reg;
                        head_reg <= best_cyl;
                        seek_reg <= seek_next;
                        rem_reg  <= rem_reg - sstf_pkg::CNT_W'(1);
                        step_reg <= '0;
                        if (last_emit)
                        begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SSTF_ASSERT_NOW(a_busy_has_work, clk, rst_n, state_reg != ST_IDLE, rem_reg != '0)
    `SSTF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= sstf_pkg::CNT_W'(D))
    `SSTF_ASSERT_NOW(a_pending_match, clk, rst_n, (state_reg == ST_SCAN) && (step_reg == '0),
        $countones(cell_vld) == int'(rem_reg))
    `SSTF_ASSERT_NEXT(a_batch_closes, clk, rst_n, emit_fire && last_emit,
        (state_reg == ST_IDLE) && (count_reg == '0) && (cell_vld == '0) && out_valid)

endmodule
